### design/msad_pkg.sv
// shared constants and types for the multiscale average distance block
package msad_pkg;

  localparam int DEF_VECTOR_LEN   = 64;
  localparam int DEF_NUM_SCALES   = 4;
  localparam int DEF_SAMPLE_WIDTH = 16;
  localparam int DEF_RAD_W        = 38;

  localparam int DIST_W     = 19;
  localparam int COUNT_W    = 7;
  localparam int OUT_SCALES = 4;
  localparam logic [63:0] DIST_MAX = 64'd524287;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_DRAIN,
    S_ROOT_GO,
    S_ROOT_WAIT,
    S_PUSH
  } msad_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } msad_root_stat_t;

endpackage

### design/msad_isqrt.sv
// iterative integer square root, one result bit per cycle
module msad_isqrt import msad_pkg::*; #(
  parameter int RAD_W = DEF_RAD_W
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [RAD_W-1:0]         radicand,
  output msad_root_stat_t          stat,
  output logic [(RAD_W+1)/2-1:0]   root
);

  localparam int RW    = RAD_W + (RAD_W % 2);
  localparam int HW    = RW / 2;
  localparam int REM_W = HW + 2;
  localparam int CW    = $clog2(HW + 1);

  logic [RW-1:0]    rad_r;
  logic [REM_W-1:0] rem_r;
  logic [REM_W-1:0] rem_nxt;
  logic [HW-1:0]    root_r;
  logic [HW-1:0]    root_nxt;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;

  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RW-1:RW-2]};
  assign trial  = {root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_comb begin
    rem_nxt  = fits ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_r[HW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(HW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= RW'(radicand);
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RW-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r;

endmodule

### design/multiscale_average_distance_top.sv
// top level of the multiscale running average distance block
//
// input words carry one vector element (in_sample_value) and a flag for the
// last element of the vector; one result word leaves on each last element
// with the four distances, the element count and the overflow flag
// both channels are valid/stall; a word moves when valid is high and stall low
// an element's row of averages is read from the average memory when it is
// taken, then the calc state updates that row and squares the differences;
// the sum into the accumulators overlaps the next element
// after the last element: the drain state, then per reported scale a pass
// through the shared square root unit (root_go, root_wait), then the push
// state loads the output register
// after reset the average memory is zeroed, one row a cycle, with
// in_stall high
// the output register holds the result while out_stall is high; elements of
// the next vector are still accepted meanwhile, and a following result waits
// in the block until the register is free
module multiscale_average_distance_top import msad_pkg::*; #(
  parameter int VECTOR_LEN   = DEF_VECTOR_LEN,
  parameter int NUM_SCALES   = DEF_NUM_SCALES,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_value,
  input  logic                           in_last_element,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [DIST_W-1:0]              out_distance_full,
  output logic [DIST_W-1:0]              out_distance_half,
  output logic [DIST_W-1:0]              out_distance_quarter,
  output logic [DIST_W-1:0]              out_distance_eighth,
  output logic [COUNT_W-1:0]             out_element_count,
  output logic                           out_overflow
);

  localparam int SW       = SAMPLE_WIDTH;
  localparam int MW       = NUM_SCALES * SW;
  localparam int AW       = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
  localparam int PW       = $clog2(VECTOR_LEN + 1);
  localparam int SQ_W     = 2 * SW;
  localparam int ACC_FULL = 2 * SW + $clog2(VECTOR_LEN);
  localparam int ACC_W    = (ACC_FULL > 64) ? 64 : ACC_FULL;
  localparam int HW       = (ACC_W + 1) / 2;
  localparam int RS       = (NUM_SCALES < OUT_SCALES) ? NUM_SCALES : OUT_SCALES;
  localparam int RIW      = (RS > 1) ? $clog2(RS) : 1;

  msad_state_t state_r;
  msad_state_t state_nxt;

  logic [MW-1:0] avg_mem [VECTOR_LEN];
  logic [MW-1:0] rd_data_r;
  logic [MW-1:0] wr_calc;
  logic [MW-1:0] wr_data;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic          wr_en;

  logic [AW-1:0]          clr_r;
  logic [PW-1:0]          pos_r;
  logic                   ovf_r;
  logic signed [SW-1:0]   x_r;
  logic                   last_r;
  logic [SQ_W-1:0]        sq_r  [RS];
  logic                   sq_vld_r;
  logic [ACC_W-1:0]       acc_r [RS];
  logic [RIW-1:0]         root_idx_r;
  logic [DIST_W-1:0]      dist_r [RS];
  logic [DIST_W-1:0]      dist_sat;

  logic                   out_vld_r;
  logic [DIST_W-1:0]      out_dist_r [OUT_SCALES];
  logic [COUNT_W-1:0]     out_count_r;
  logic                   out_ovf_r;

  logic                   in_fire;
  logic                   in_room;
  logic                   push;
  logic                   root_start;
  msad_root_stat_t        root_stat;
  logic [HW-1:0]          root;

  assign in_fire = in_valid && !in_stall;
  assign in_room = (pos_r < PW'(VECTOR_LEN));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == AW'(VECTOR_LEN - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_room) state_nxt = S_CALC;
          else if (in_last_element) state_nxt = S_DRAIN;
        end
      end
      S_CALC: state_nxt = last_r ? S_DRAIN : S_IDLE;
      S_DRAIN: state_nxt = S_ROOT_GO;
      S_ROOT_GO: state_nxt = S_ROOT_WAIT;
      S_ROOT_WAIT: begin
        if (root_stat.done) begin
          state_nxt = (root_idx_r == RIW'(RS - 1)) ? S_PUSH : S_ROOT_GO;
        end
      end
      S_PUSH: begin
        if (!out_vld_r || !out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_stall   = 1'b1;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = pos_r[AW-1:0];
    wr_data    = wr_calc;
    root_start = 1'b0;
    push       = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        rd_en    = in_valid && in_room;
      end
      S_CALC: wr_en = 1'b1;
      S_DRAIN: ;
      S_ROOT_GO: root_start = 1'b1;
      S_ROOT_WAIT: ;
      S_PUSH: push = !out_vld_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // average memory, one row of all scales per element position
  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= avg_mem[pos_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr_en) avg_mem[wr_addr] <= wr_data;
  end

  // per scale difference, square and average update
  for (genvar s = 0; s < NUM_SCALES; s++) begin : g_scale
    logic signed [SW-1:0] avg;
    logic signed [SW:0]   diff;
    logic [SW:0]          mag;
    logic signed [SW:0]   step;
    logic signed [SW:0]   upd;

    assign avg  = rd_data_r[s*SW +: SW];
    assign diff = $signed({x_r[SW-1], x_r}) - $signed({avg[SW-1], avg});
    assign mag  = diff[SW] ? (~diff + 1'b1) : diff;
    assign step = diff >>> s;
    assign upd  = $signed({avg[SW-1], avg}) + step;
    assign wr_calc[s*SW +: SW] = upd[SW-1:0];

    if (s < RS) begin : g_sq
      always_ff @(posedge clk) begin
        if (state_r == S_CALC) sq_r[s] <= SQ_W'(mag[SW-1:0]) * SQ_W'(mag[SW-1:0]);
      end
    end
  end

  // element bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r    <= '0;
      pos_r    <= '0;
      ovf_r    <= 1'b0;
      sq_vld_r <= 1'b0;
    end else begin
      sq_vld_r <= (state_r == S_CALC);
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (state_r == S_CALC) pos_r <= pos_r + 1'b1;
      if (in_fire && !in_room) ovf_r <= 1'b1;
      if (push) begin
        pos_r <= '0;
        ovf_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r    <= in_sample_value;
      last_r <= in_last_element;
    end
  end

  // saturating accumulators
  for (genvar s = 0; s < RS; s++) begin : g_acc
    logic [ACC_W:0] sum;

    assign sum = {1'b0, acc_r[s]} + (ACC_W + 1)'(sq_r[s]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        acc_r[s] <= '0;
      end else if (push) begin
        acc_r[s] <= '0;
      end else if (sq_vld_r) begin
        acc_r[s] <= sum[ACC_W] ? '1 : sum[ACC_W-1:0];
      end
    end
  end

  // shared square root over the scales
  msad_isqrt #(
    .RAD_W (ACC_W)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (acc_r[root_idx_r]),
    .stat     (root_stat),
    .root     (root)
  );

  assign dist_sat = (64'(root) > DIST_MAX) ? DIST_MAX[DIST_W-1:0] : DIST_W'(root);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_idx_r <= '0;
    end else if (push) begin
      root_idx_r <= '0;
    end else if (state_r == S_ROOT_WAIT && root_stat.done &&
                 root_idx_r != RIW'(RS - 1)) begin
      root_idx_r <= root_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_ROOT_WAIT && root_stat.done) dist_r[root_idx_r] <= dist_sat;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (push) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  for (genvar j = 0; j < OUT_SCALES; j++) begin : g_out
    if (j < RS) begin : g_used
      always_ff @(posedge clk) begin
        if (push) out_dist_r[j] <= dist_r[j];
      end
    end else begin : g_unused
      always_ff @(posedge clk) begin
        if (push) out_dist_r[j] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_count_r <= COUNT_W'(pos_r);
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_distance_full    = out_dist_r[0];
  assign out_distance_half    = out_dist_r[1];
  assign out_distance_quarter = out_dist_r[2];
  assign out_distance_eighth  = out_dist_r[3];
  assign out_element_count    = out_count_r;
  assign out_overflow         = out_ovf_r;

  // checks
  a_root_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    root_start |-> !root_stat.busy)
    else $error("square root started while busy");

  a_root_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    root_stat.done |-> (state_r == S_ROOT_WAIT))
    else $error("square root result outside wait state");

  a_push_drained: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !sq_vld_r)
    else $error("result loaded with a square still pending");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PW'(VECTOR_LEN))
    else $error("element position past vector length");

endmodule

### test/multiscale_average_distance_top_tb.sv
// self-checking testbench for the multiscale average distance block
module multiscale_average_distance_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import msad_pkg::*;

  localparam int VLEN = DEF_VECTOR_LEN;
  localparam int SCALES = DEF_NUM_SCALES;
  localparam int SW = DEF_SAMPLE_WIDTH;
  localparam int ITEM_GOAL = 1050;
  localparam int VECTOR_GOAL = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 200;
  localparam int QUIET_FROM = 2000;
  localparam int QUIET_TO = 4500;

  typedef struct {
    logic signed [SW-1:0] sample;
    logic                 last;
    bit                   drain;
  } element_word_t;

  typedef struct {
    logic [OUT_SCALES-1:0][DIST_W-1:0] dist_vals;
    logic [COUNT_W-1:0]                count;
    logic                              ovf;
  } distance_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SW-1:0] in_sample_value = '0;
  logic in_last_element = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DIST_W-1:0] out_distance_full;
  logic [DIST_W-1:0] out_distance_half;
  logic [DIST_W-1:0] out_distance_quarter;
  logic [DIST_W-1:0] out_distance_eighth;
  logic [COUNT_W-1:0] out_element_count;
  logic out_overflow;

  element_word_t element_words[$];
  distance_word_t expected_distances[$];
  element_word_t next_word;

  logic signed [SW-1:0] avg_mem [SCALES][VLEN];
  longint unsigned dist_sum [SCALES];
  int elem_pos;
  bit ovf_seen;

  int fail_count = 0;
  int cycle_count = 0;

  multiscale_average_distance_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sample_value(in_sample_value),
    .in_last_element(in_last_element),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_distance_full(out_distance_full),
    .out_distance_half(out_distance_half),
    .out_distance_quarter(out_distance_quarter),
    .out_distance_eighth(out_distance_eighth),
    .out_element_count(out_element_count),
    .out_overflow(out_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] rem;
    res = '0;
    bitv = 64'd1 << 62;
    rem = n;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  task automatic fold_element(input logic signed [SW-1:0] x, input logic last);
    distance_word_t w;
    int diff;
    logic [63:0] d;
    if (elem_pos < VLEN) begin
      for (int s = 0; s < SCALES; s++) begin
        diff = int'(x) - int'(avg_mem[s][elem_pos]);
        dist_sum[s] += longint'(diff) * longint'(diff);
        avg_mem[s][elem_pos] = avg_mem[s][elem_pos] + SW'(diff >>> s);
      end
      elem_pos++;
    end else begin
      ovf_seen = 1'b1;
    end
    if (last) begin
      for (int j = 0; j < OUT_SCALES; j++) begin
        d = '0;
        if (j < SCALES) begin
          d = root_floor(dist_sum[j]);
          if (d > DIST_MAX) d = DIST_MAX;
        end
        w.dist_vals[j] = DIST_W'(d);
      end
      w.count = COUNT_W'(elem_pos);
      w.ovf = ovf_seen;
      expected_distances.push_back(w);
      for (int s = 0; s < SCALES; s++) dist_sum[s] = 0;
      elem_pos = 0;
      ovf_seen = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    fail_count++;
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
  endtask

  task automatic check_result();
    distance_word_t w;
    if (expected_distances.size() == 0) begin
      report_mismatch("unexpected result word, count", out_element_count, 0);
    end else begin
      w = expected_distances.pop_front();
      if (out_distance_full !== w.dist_vals[0])
        report_mismatch("distance_full", out_distance_full, w.dist_vals[0]);
      if (out_distance_half !== w.dist_vals[1])
        report_mismatch("distance_half", out_distance_half, w.dist_vals[1]);
      if (out_distance_quarter !== w.dist_vals[2])
        report_mismatch("distance_quarter", out_distance_quarter, w.dist_vals[2]);
      if (out_distance_eighth !== w.dist_vals[3])
        report_mismatch("distance_eighth", out_distance_eighth, w.dist_vals[3]);
      if (out_element_count !== w.count)
        report_mismatch("element_count", out_element_count, w.count);
      if (out_overflow !== w.ovf)
        report_mismatch("overflow", out_overflow, w.ovf);
    end
  endtask

  function automatic bit side_idles();
    if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
    return $urandom_range(99) < 16;
  endfunction

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return SW'(int'($urandom_range(511)) - 256);
      default: return SW'($urandom);
    endcase
  endfunction

  task automatic queue_vector(input int len, input bit drain);
    for (int i = 0; i < len; i++)
      element_words.push_back('{pick_sample(), i == len - 1, drain && i == 0});
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) fold_element(in_sample_value, in_last_element);
      if (element_words.size() > 0 && !side_idles() &&
          !(element_words[0].drain && expected_distances.size() > 0)) begin
        next_word = element_words.pop_front();
        in_valid <= 1'b1;
        in_sample_value <= next_word.sample;
        in_last_element <= next_word.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      out_stall <= side_idles();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("multiscale_average_distance_top_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int n_items;
    int n_vectors;
    int len;
    int r;
    for (int s = 0; s < SCALES; s++) begin
      dist_sum[s] = 0;
      for (int p = 0; p < VLEN; p++) avg_mem[s][p] = '0;
    end
    elem_pos = 0;
    ovf_seen = 1'b0;

    // extremes, short vectors and bit patterns
    element_words.push_back('{16'sh7fff, 1'b1, 1'b0});
    element_words.push_back('{16'sh8000, 1'b1, 1'b0});
    element_words.push_back('{16'sh8000, 1'b1, 1'b0});
    element_words.push_back('{16'sh0001, 1'b0, 1'b0});
    element_words.push_back('{16'shffff, 1'b0, 1'b0});
    element_words.push_back('{16'sh5555, 1'b0, 1'b0});
    element_words.push_back('{16'shaaaa, 1'b1, 1'b0});
    element_words.push_back('{16'sh7fff, 1'b0, 1'b0});
    element_words.push_back('{16'sh7fff, 1'b0, 1'b0});
    element_words.push_back('{16'sh8000, 1'b0, 1'b0});
    element_words.push_back('{16'sh0000, 1'b0, 1'b0});
    element_words.push_back('{16'sh8000, 1'b1, 1'b0});
    element_words.push_back('{16'sh0000, 1'b1, 1'b0});
    for (int i = 0; i < 6; i++)
      element_words.push_back('{(i % 2 == 0) ? 16'sh7fff : 16'sh8000, i == 5, i == 0});

    // full vector, then one running past the bound
    queue_vector(VLEN, 1'b0);
    queue_vector(VLEN + 3, 1'b1);

    n_items = element_words.size();
    n_vectors = 0;
    while (n_items < ITEM_GOAL || n_vectors < VECTOR_GOAL) begin
      r = $urandom_range(99);
      if (r < 70) len = $urandom_range(12, 1);
      else if (r < 85) len = $urandom_range(VLEN - 1, 13);
      else if (r < 93) len = VLEN;
      else len = $urandom_range(VLEN + 8, VLEN + 1);
      queue_vector(len, $urandom_range(99) < 5);
      n_items += len;
      n_vectors++;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (element_words.size() > 0 || in_valid || expected_distances.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("multiscale_average_distance_top_tb: PASS");
    end else begin
      $display("multiscale_average_distance_top_tb: FAIL");
    end
    $finish;
  end

endmodule

### multiscale_average_distance_top.f
design/msad_pkg.sv
design/msad_isqrt.sv
design/multiscale_average_distance_top.sv
test/multiscale_average_distance_top_tb.sv
